// ===== hdl/scanline_polygon_span_fill_assert.svh =====
// assertion macros for the span fill block
`ifndef SCANLINE_POLYGON_SPAN_FILL_ASSERT_SVH
`define SCANLINE_POLYGON_SPAN_FILL_ASSERT_SVH
`ifndef SYNTHESIS
`define SPF_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define SPF_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SPF_ASSERT_IMP(label, clk, rst_n, a, c)
`define SPF_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== hdl/spf_pkg.sv =====
package spf_pkg;
	localparam int MAX_SPANS = 8;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_ROW  = 1'b1
	} req_t;
endpackage

// ===== hdl/scanline_polygon_span_fill.sv =====
// channel   | signals                                  | transfer
// command   | req_type start_new vertex_x vertex_y row | start && !busy
// result    | span_row span_start span_end span_valid last_span | span_strobe
// a load is taken in the idle state; a row does a read setup step, then per edge a read and a
// test, per crossing a bit-serial divide and an insert that shifts larger entries up, then one strobe per span
// the worst case is set by the bit-serial divider and the insert shift
// vertex memory has no reset; only vertex count and control clear on arst_n
// results cannot be stalled; busy holds off commands while a row is worked
`include "scanline_polygon_span_fill_assert.svh"
module scanline_polygon_span_fill
	import spf_pkg::*;
#(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic                  start_new,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic [COORD_BITS-1:0] row,
	output logic                  span_strobe,
	output logic [COORD_BITS-1:0] span_row,
	output logic [COORD_BITS-1:0] span_start,
	output logic [COORD_BITS-1:0] span_end,
	output logic                  span_valid,
	output logic                  last_span
);
	logic [$clog2(MAX_VERTICES+1)-1:0] vcount;

	spf_engine #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_eng (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.start_new(start_new), .vertex_x(vertex_x), .vertex_y(vertex_y), .row(row),
		.span_strobe(span_strobe), .span_row(span_row), .span_start(span_start),
		.span_end(span_end), .span_valid(span_valid), .last_span(last_span),
		.vert_count(vcount)
	);

	`SPF_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, vcount <= MAX_VERTICES)
	`SPF_ASSERT_IMP(a_invalid_last, clk, arst_n, span_strobe && !span_valid, last_span)
	`SPF_ASSERT_IMP(a_order, clk, arst_n, span_strobe && span_valid, span_start <= span_end)
	`SPF_ASSERT_IMP(a_last_idle, clk, arst_n, span_strobe && last_span, !busy)
	`SPF_ASSERT_NXT(a_row_busy, clk, arst_n, start && !busy && req_type == REQ_ROW, busy)
endmodule

// ===== hdl/spf_divider.sv =====
// restoring divider, one quotient bit per cycle, magnitudes only
module spf_divider #(
	parameter int NB = 20,
	parameter int DB = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [NB-1:0] num,
	input  logic [DB-1:0] den,
	output logic          done,
	output logic [NB-1:0] quo
);
	localparam int CB = $clog2(NB + 1);

	logic [NB-1:0] n_q;
	logic [DB:0]   r_q;
	logic [DB-1:0] d_q;
	logic [CB-1:0] cnt_q;
	logic          run_q;
	logic [DB:0]   shr;
	logic          ge;

	assign shr = {r_q[DB-1:0], n_q[NB-1]};
	assign ge  = shr >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CB'(NB);
				n_q   <= num;
				d_q   <= den;
				r_q   <= '0;
			end else if (run_q) begin
				r_q   <= ge ? shr - {1'b0, d_q} : shr;
				n_q   <= {n_q[NB-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end
	assign quo = n_q;
endmodule

// ===== hdl/spf_engine.sv =====
// sequencer: vertex memory, edge walk, insertion into sorted crossing list, span output
module spf_engine
	import spf_pkg::*;
#(
	parameter int MAX_VERTICES = 16,
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic                  start_new,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic [COORD_BITS-1:0] row,
	output logic                  span_strobe,
	output logic [COORD_BITS-1:0] span_row,
	output logic [COORD_BITS-1:0] span_start,
	output logic [COORD_BITS-1:0] span_end,
	output logic                  span_valid,
	output logic                  last_span,
	output logic [$clog2(MAX_VERTICES+1)-1:0] vert_count
);
	localparam int AB = $clog2(MAX_VERTICES);
	localparam int VB = $clog2(MAX_VERTICES + 1);
	localparam int CB = COORD_BITS;
	localparam int NB = 2 * CB;
	localparam int SB = $clog2(MAX_SPANS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD0, ST_RDA, ST_RDB, ST_EDGE, ST_DIV, ST_INS,
		ST_OUT, ST_EMPTY
	} state_t;

	state_t         state_q;
	logic [NB-1:0]  mem [MAX_VERTICES];
	logic [NB-1:0]  rd_q;
	logic [AB-1:0]  rd_addr;
	logic           rd_en;
	logic [VB-1:0]  cnt_q;
	logic [VB-1:0]  edge_q;
	logic [CB-1:0]  row_q;
	logic [CB-1:0]  x0_q, y0_q, x1_q, y1_q, fx_q, fy_q;
	logic [CB-1:0]  cross_q [MAX_VERTICES];
	logic [VB-1:0]  k_q;
	logic [VB-1:0]  ins_q;
	logic [CB-1:0]  val_q;
	logic           neg_q;
	logic [SB-1:0]  sp_q;
	logic           div_go;
	logic           div_done;
	logic [NB-1:0]  div_num, quo;
	logic [CB:0]    div_den;
	logic [CB:0]    dx, dy;
	logic [CB:0]    adx, ady, dp, adp;
	logic [NB-1:0]  prod;
	logic           hit;
	logic [CB-1:0]  lin;
	logic [CB-1:0]  cx;
	logic [VB-1:0]  half;

	always_ff @(posedge clk) begin
		if (start && !busy && req_type == REQ_LOAD && (start_new || cnt_q < VB'(MAX_VERTICES)))
			mem[start_new ? AB'(0) : cnt_q[AB-1:0]] <= {vertex_x, vertex_y};
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign hit = (y0_q <= row_q && y1_q > row_q) || (y0_q > row_q && y1_q <= row_q);
	assign dx  = {1'b0, x1_q} - {1'b0, x0_q};
	assign dy  = {1'b0, y1_q} - {1'b0, y0_q};
	assign dp  = {1'b0, row_q} - {1'b0, y0_q};
	assign adx = dx[CB] ? -dx : dx;
	assign ady = dy[CB] ? -dy : dy;
	assign adp = dp[CB] ? -dp : dp;
	assign prod = NB'(adx[CB-1:0]) * NB'(adp[CB-1:0]);
	assign div_num = prod;
	assign div_den = ady;
	assign lin = quo[CB-1:0];
	assign cx  = neg_q ? x0_q - lin : x0_q + lin;
	assign half = k_q >> 1;

	spf_divider #(.NB(NB), .DB(CB + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.done(div_done), .quo(quo)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		div_go  = 1'b0;
		case (state_q)
			ST_RD0: begin
				rd_en = 1'b1;
				rd_addr = '0;
			end
			ST_RDA: begin
				rd_en = 1'b1;
				rd_addr = (edge_q + 1'b1 < cnt_q) ? AB'(edge_q + 1'b1) : '0;
			end
			ST_EDGE: div_go = hit;
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			span_strobe <= 1'b0;
			k_q         <= '0;
		end else begin
			span_strobe <= 1'b0;
			case (state_q)
				ST_IDLE: if (start) begin
					row_q <= row;
					if (req_type == REQ_LOAD) begin
						if (start_new) cnt_q <= VB'(1);
						else if (cnt_q < VB'(MAX_VERTICES)) cnt_q <= cnt_q + 1'b1;
					end else begin
						k_q    <= '0;
						edge_q <= '0;
						state_q <= (cnt_q < VB'(2)) ? ST_EMPTY : ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RDA;
				ST_RDA: begin
					// first word back is vertex 0, kept for the closing edge
					if (edge_q == '0) begin
						{fx_q, fy_q} <= rd_q;
						{x0_q, y0_q} <= rd_q;
					end
					state_q <= ST_RDB;
				end
				ST_RDB: begin
					{x1_q, y1_q} <= (edge_q + 1'b1 < cnt_q) ? rd_q[NB-1:0] : {fx_q, fy_q};
					state_q <= ST_EDGE;
				end
				ST_EDGE: begin
					neg_q <= dx[CB] ^ dp[CB] ^ dy[CB];
					if (hit) state_q <= ST_DIV;
					else if (edge_q + 1'b1 < cnt_q) begin
						edge_q <= edge_q + 1'b1;
						{x0_q, y0_q} <= {x1_q, y1_q};
						state_q <= ST_RDA;
					end else state_q <= ST_OUT;
					sp_q  <= '0;
				end
				ST_DIV: if (div_done) begin
					val_q <= cx;
					ins_q <= k_q;
					state_q <= ST_INS;
				end
				ST_INS: begin
					// shift larger entries up one per cycle
					if (ins_q != '0 && cross_q[AB'(ins_q - 1'b1)] > val_q) begin
						cross_q[AB'(ins_q)] <= cross_q[AB'(ins_q - 1'b1)];
						ins_q <= ins_q - 1'b1;
					end else begin
						cross_q[AB'(ins_q)] <= val_q;
						k_q <= k_q + 1'b1;
						if (edge_q + 1'b1 < cnt_q) begin
							edge_q <= edge_q + 1'b1;
							{x0_q, y0_q} <= {x1_q, y1_q};
							state_q <= ST_RDA;
						end else state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (half == '0) state_q <= ST_EMPTY;
					else begin
						span_strobe <= 1'b1;
						span_row    <= row_q;
						span_start  <= cross_q[AB'({sp_q, 1'b0})];
						span_end    <= cross_q[AB'({sp_q, 1'b1})];
						span_valid  <= 1'b1;
						last_span   <= (VB'(sp_q) + 1'b1 == half) ||
							(sp_q + 1'b1 == SB'(MAX_SPANS));
						sp_q <= sp_q + 1'b1;
						if ((VB'(sp_q) + 1'b1 == half) || (sp_q + 1'b1 == SB'(MAX_SPANS)))
							state_q <= ST_IDLE;
					end
				end
				ST_EMPTY: begin
					span_strobe <= 1'b1;
					span_row    <= row_q;
					span_start  <= '0;
					span_end    <= '0;
					span_valid  <= 1'b0;
					last_span   <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
	assign vert_count = cnt_q;
endmodule
